// ===== rtl/tsr_pkg.sv =====
// ----------------------------------------------------------------------------
// TCP timestamp rewriter package
// Item types for the packet byte channel and the result channel, and the
// protocol constants used while walking the headers.
// ----------------------------------------------------------------------------
package tsr_pkg;

  typedef struct packed {
    logic [7:0]  pkt_byte;
    logic        first_byte;
    logic        last_byte;
    logic        do_measure;
    logic        do_stamp;
    logic [31:0] now_us;
    logic [31:0] echo_replace;
    logic [31:0] new_tsval;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic        ts_found;
    logic [31:0] rtt_us;
  } out_item_t;

  // Header layout and option codes.
  localparam logic [7:0] IP_PROTO_TCP     = 8'd6;
  localparam logic [6:0] IP_PROTO_POS     = 7'd9;
  localparam logic [5:0] IP_HDR_MIN       = 6'd20;
  localparam logic [6:0] TCP_OFFSET_POS   = 7'd12;
  localparam logic [6:0] TCP_OPT_START    = 7'd20;
  localparam logic [5:0] TCP_HDR_MIN_TS   = 6'd30;
  localparam logic [7:0] OPT_KIND_END     = 8'd0;
  localparam logic [7:0] OPT_KIND_NOP     = 8'd1;
  localparam logic [7:0] OPT_KIND_TS      = 8'd8;
  localparam logic [7:0] OPT_LEN_TS       = 8'd10;
  localparam logic [7:0] OPT_LEN_MIN      = 8'd2;
  localparam logic [6:0] POS_MAX          = 7'd127;

endpackage

// ===== rtl/tsr_parser.sv =====
// ----------------------------------------------------------------------------
// TCP timestamp rewriter parser
// Holds the per-packet parse state, which advances only while the enable
// is high, and turns one packet byte into one result item.
// ----------------------------------------------------------------------------
module tsr_parser import tsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  in_item_t  item,
  output out_item_t result
);

  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_KIND   = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_LEN_TS = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_TS     = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  logic [6:0]  pos,       pos_next;
  logic [5:0]  ihl,       ihl_next;
  logic [5:0]  tcp_len,   tcp_len_next;
  logic        is_tcp,    is_tcp_next;
  logic [2:0]  phase,     phase_next;
  logic [6:0]  opt_off,   opt_off_next;
  logic [7:0]  opt_len,   opt_len_next;
  logic [31:0] echo_cap,  echo_cap_next;
  logic        found,     found_next;
  logic [31:0] lat_now,   lat_now_next;
  logic [31:0] lat_echo,  lat_echo_next;
  logic [31:0] lat_tsval, lat_tsval_next;
  logic [1:0]  modes,     modes_next;

  logic [6:0]  t;
  logic [6:0]  k;
  logic [1:0]  sel;
  logic [8:0]  opt_end;
  logic [7:0]  b;

  // Big-endian byte of a 32-bit word, index 0 is the most significant byte.
  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  always_comb begin
    b              = item.pkt_byte;
    pos_next       = pos;
    ihl_next       = ihl;
    tcp_len_next   = tcp_len;
    is_tcp_next    = is_tcp;
    phase_next     = phase;
    opt_off_next   = opt_off;
    opt_len_next   = opt_len;
    echo_cap_next  = echo_cap;
    found_next     = found;
    lat_now_next   = lat_now;
    lat_echo_next  = lat_echo;
    lat_tsval_next = lat_tsval;
    modes_next     = modes;
    t              = '0;
    k              = '0;
    sel            = '0;
    opt_end        = '0;
    result.out_byte = b;

    // A first byte starts a fresh packet and samples the per-packet controls.
    if (item.first_byte) begin
      pos_next       = '0;
      ihl_next       = '0;
      tcp_len_next   = '0;
      is_tcp_next    = 1'b0;
      phase_next     = PH_WAIT;
      opt_off_next   = '0;
      opt_len_next   = '0;
      echo_cap_next  = '0;
      found_next     = 1'b0;
      modes_next     = {item.do_measure, item.do_stamp};
      lat_now_next   = item.now_us;
      lat_echo_next  = item.echo_replace;
      lat_tsval_next = item.new_tsval;
    end

    if (pos_next == '0) begin
      ihl_next = {b[3:0], 2'b00};
    end
    if (pos_next == IP_PROTO_POS) begin
      is_tcp_next = (b == IP_PROTO_TCP);
    end

    if (is_tcp_next && ihl_next >= IP_HDR_MIN && pos_next >= {1'b0, ihl_next}
        && phase_next != PH_DONE) begin
      t = pos_next - {1'b0, ihl_next};
      if (t == TCP_OFFSET_POS) begin
        tcp_len_next = {b[7:4], 2'b00};
        if ({b[7:4], 2'b00} < TCP_HDR_MIN_TS) begin
          phase_next = PH_DONE;
        end
      end else if (t >= TCP_OPT_START) begin
        if (t >= {1'b0, tcp_len_next}) begin
          phase_next = PH_DONE;
        end else begin
          if (phase_next == PH_WAIT && t == TCP_OPT_START) begin
            phase_next = PH_KIND;
          end
          unique case (phase_next)
            PH_KIND: begin
              if (b == OPT_KIND_END) begin
                phase_next = PH_DONE;
              end else if (b == OPT_KIND_NOP) begin
                phase_next = PH_KIND;
              end else if ({1'b0, t} + 8'd1 >= {2'b00, tcp_len_next}) begin
                phase_next = PH_DONE;
              end else begin
                opt_off_next = t;
                phase_next   = (b == OPT_KIND_TS) ? PH_LEN_TS : PH_LEN;
              end
            end
            PH_LEN, PH_LEN_TS: begin
              opt_len_next = b;
              opt_end      = {2'b00, opt_off_next} + {1'b0, b};
              if (b < OPT_LEN_MIN || opt_end > {3'b000, tcp_len_next}) begin
                phase_next = PH_DONE;
              end else if (phase_next == PH_LEN_TS && b == OPT_LEN_TS) begin
                phase_next = PH_TS;
              end else if (b == OPT_LEN_MIN) begin
                phase_next = PH_KIND;
              end else begin
                phase_next = PH_SKIP;
              end
            end
            PH_SKIP: begin
              opt_end = {2'b00, opt_off_next} + {1'b0, opt_len_next};
              if ({2'b00, t} + 9'd1 == opt_end) begin
                phase_next = PH_KIND;
              end
            end
            PH_TS: begin
              k   = t - opt_off_next;
              sel = k[1:0] + 2'd2;
              if (k >= 7'd2 && k <= 7'd5) begin
                if (modes_next[0]) begin
                  result.out_byte = be_byte(lat_tsval_next, sel);
                end
              end else if (k >= 7'd6 && k <= 7'd9) begin
                echo_cap_next = {echo_cap_next[23:0], b};
                if (modes_next[1]) begin
                  result.out_byte = be_byte(lat_echo_next, sel);
                end
                if (k == 7'd9) begin
                  found_next = 1'b1;
                  phase_next = PH_DONE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    result.out_last = item.last_byte;
    result.ts_found = item.last_byte & found_next;
    result.rtt_us   = (item.last_byte && found_next && modes_next[1]) ?
                      (lat_now_next - echo_cap_next) : 32'd0;

    // After the last byte the block idles until the next first byte.
    if (item.last_byte) begin
      pos_next      = POS_MAX;
      ihl_next      = '0;
      tcp_len_next  = '0;
      is_tcp_next   = 1'b0;
      phase_next    = PH_DONE;
      opt_off_next  = '0;
      opt_len_next  = '0;
      echo_cap_next = '0;
      found_next    = 1'b0;
    end else if (pos_next < POS_MAX) begin
      pos_next = pos_next + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      ihl       <= '0;
      tcp_len   <= '0;
      is_tcp    <= 1'b0;
      phase     <= PH_WAIT;
      opt_off   <= '0;
      opt_len   <= '0;
      echo_cap  <= '0;
      found     <= 1'b0;
      lat_now   <= '0;
      lat_echo  <= '0;
      lat_tsval <= '0;
      modes     <= '0;
    end else if (en) begin
      pos       <= pos_next;
      ihl       <= ihl_next;
      tcp_len   <= tcp_len_next;
      is_tcp    <= is_tcp_next;
      phase     <= phase_next;
      opt_off   <= opt_off_next;
      opt_len   <= opt_len_next;
      echo_cap  <= echo_cap_next;
      found     <= found_next;
      lat_now   <= lat_now_next;
      lat_echo  <= lat_echo_next;
      lat_tsval <= lat_tsval_next;
      modes     <= modes_next;
    end
  end

endmodule

// ===== rtl/tcp_timestamp_option_rewriter.sv =====
// ----------------------------------------------------------------------------
// TCP timestamp option rewriter
// Byte-serial IPv4/TCP parser that rewrites TSval and TSecr in place and
// reports whether a timestamp option was seen and the measured RTT.
// ----------------------------------------------------------------------------
// The block takes one packet byte per item on the pkt channel, starting at
// the IPv4 header, and returns exactly one result item per byte on the res
// channel, in order. It sustains one item per clock while res_ready is high:
// a byte is captured in an input register, the parser updates its
// per-packet state and forms the result combinationally, and the result
// lands in an output register. The input side keeps accepting while a
// result waits, as long as the output register will be freed in the same
// cycle; pkt_ready follows res_ready combinationally.
// The per-packet controls (do_measure, do_stamp, now_us, echo_replace,
// new_tsval) are sampled only on the item that carries first_byte. ts_found
// and rtt_us are meaningful only on the item that carries out_last and are
// zero on every other item. After a last byte, further bytes without
// first_byte pass through untouched.
module tcp_timestamp_option_rewriter import tsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pkt_valid,
  output logic      pkt_ready,
  input  in_item_t  pkt,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  logic      hold_valid;
  in_item_t  hold;
  logic      advance;
  out_item_t parsed;

  // The held item moves on whenever the output register is empty or drains.
  assign advance   = hold_valid && (!res_valid || res_ready);
  assign pkt_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (pkt_ready) begin
      hold_valid <= pkt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_ready && pkt_valid) begin
      hold <= pkt;
    end
  end

  tsr_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (hold),
    .result (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= parsed;
    end
  end

endmodule

// ===== rtl/tsr_checker.sv =====
// ----------------------------------------------------------------------------
// TCP timestamp rewriter checker
// Port-level assertions for the rewriter, bound to the top level.
// ----------------------------------------------------------------------------
module tsr_checker import tsr_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      pkt_valid,
  input logic      pkt_ready,
  input in_item_t  pkt,
  input logic      res_valid,
  input logic      res_ready,
  input out_item_t res
);

  // A stalled result must hold.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // Status fields are only reported on the last byte of a packet.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.out_last |-> !res.ts_found && res.rtt_us == 32'd0)
    else $error("status reported on a byte that is not last");

  // An RTT is only reported when a timestamp option was found.
  a_rtt_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.ts_found |-> res.rtt_us == 32'd0)
    else $error("rtt reported without a timestamp option");

  // A byte accepted into an empty block passes the input register and then the output register.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_ready && !res_valid && $past(!pkt_valid || !pkt_ready) &&
    !$past(rst) ##1 res_ready |=> res_valid && res.out_last == $past(pkt.last_byte, 2))
    else $error("accepted byte did not reach the output in two cycles");

endmodule

bind tcp_timestamp_option_rewriter tsr_checker u_tsr_checker (
  .clk       (clk),
  .rst       (rst),
  .pkt_valid (pkt_valid),
  .pkt_ready (pkt_ready),
  .pkt       (pkt),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
